// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, widths and codes for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int STAT_W  = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_ZERO     = 3'd2,
        ST_IDLE     = 3'd3,
        ST_RAN      = 3'd4,
        ST_FINISHED = 3'd5
    } pps_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_UPDATE,
        S_FINISH,
        S_RESULT
    } pps_state_t;

    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [PRIO_W-1:0] priority_lvl;
    } pps_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic idx_inc;
        logic scan_rd;
        logic best_rd;
        logic time_inc;
        logic write_job;
        logic set_full;
        logic set_idle;
        logic update;
        logic finish;
    } pps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic idx_last;
        logic best_found;
    } pps_stat_t;

endpackage

// ===== hw/rtl/preemptive_priority_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Ready table of jobs with serial lowest-priority selection per time tick.
//
//   channel   ports                                         handshake
//   input     kind job_id job_burst job_priority            start, busy
//   result    status run_id finish_time turnaround          done
//             waiting time_now
//
// an arrival searches for a free slot, one slot a cycle, then stores the job
// a tick is a serial scan of every slot through the entry memory's single
// read port, then a read and update of the winning entry
// one result word per item, shown for the single cycle done is high
// busy is high from the cycle after start until the result cycle ends
// the receiver cannot stall, so a result word is never held back
// reset clears the valid bits and the time at once, no clearing pass
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [pps_pkg::ID_W-1:0]    job_id,
    input  logic [pps_pkg::TIME_W-1:0]  job_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  job_priority,
    output logic                        done,
    output logic [pps_pkg::STAT_W-1:0]  status,
    output logic [pps_pkg::ID_W-1:0]    run_id,
    output logic [pps_pkg::TIME_W-1:0]  finish_time,
    output logic [pps_pkg::TIME_W-1:0]  turnaround,
    output logic [pps_pkg::TIME_W-1:0]  waiting,
    output logic [pps_pkg::TIME_W-1:0]  time_now
);
    import pps_pkg::*;

    pps_cmd_t  cmd;
    pps_stat_t stat;

    pps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .job_id       (job_id),
        .job_burst    (job_burst),
        .job_priority (job_priority),
        .status       (status),
        .run_id       (run_id),
        .finish_time  (finish_time),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .time_now     (time_now)
    );

    // controller returns to idle right after a result
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result cycle");

    // time never moves backward
    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (time_now >= $past(time_now)))
        else $error("time decreased");

    // a finished job never waits longer than its turnaround
    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FINISHED)) |-> (waiting <= turnaround))
        else $error("waiting exceeds turnaround");

    // time only advances on a tick, so an arrival reports an unchanged time
    a_arrival_time: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((status == ST_ACCEPTED) || (status == ST_FULL) || (status == ST_ZERO)))
        |-> $stable(time_now))
        else $error("time moved on an arrival");

endmodule

// ===== hw/rtl/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for arrivals (free slot search, store) and ticks (serial priority
// scan, run the winner, report).
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                kind,
    input  pps_pkg::pps_stat_t  stat,
    output pps_pkg::pps_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import pps_pkg::*;

    pps_state_t state_reg;
    pps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = kind ? S_SCAN : S_FREE;
                end
            end
            S_FREE:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_WRITE;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_WRITE:  state_next = S_RESULT;
            S_SCAN:
            begin
                if (stat.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_READ;
            S_READ:   state_next = stat.best_found ? S_UPDATE : S_RESULT;
            S_UPDATE: state_next = S_FINISH;
            S_FINISH: state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_FREE:
            begin
                cmd.idx_inc  = !stat.slot_free && !stat.idx_last;
                cmd.set_full = !stat.slot_free && stat.idx_last;
            end
            S_WRITE:  cmd.write_job = 1'b1;
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_DRAIN:  ;
            S_READ:
            begin
                cmd.time_inc = 1'b1;
                cmd.best_rd  = stat.best_found;
                cmd.set_idle = !stat.best_found;
            end
            S_UPDATE: cmd.update = 1'b1;
            S_FINISH: cmd.finish = 1'b1;
            S_RESULT: done = 1'b1;
            default:  ;
        endcase
    end

endmodule

// ===== hw/rtl/pps_datapath.sv =====
// ----------------------------------------------------------------------------
// pps_datapath
// Job table (valid flops plus entry memory), scan comparator, time counter
// and result registers.
// ----------------------------------------------------------------------------
module pps_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pps_pkg::pps_cmd_t           cmd,
    output pps_pkg::pps_stat_t          stat,
    input  logic [pps_pkg::ID_W-1:0]    job_id,
    input  logic [pps_pkg::TIME_W-1:0]  job_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  job_priority,
    output logic [pps_pkg::STAT_W-1:0]  status,
    output logic [pps_pkg::ID_W-1:0]    run_id,
    output logic [pps_pkg::TIME_W-1:0]  finish_time,
    output logic [pps_pkg::TIME_W-1:0]  turnaround,
    output logic [pps_pkg::TIME_W-1:0]  waiting,
    output logic [pps_pkg::TIME_W-1:0]  time_now
);
    import pps_pkg::*;

    logic [SLOTS-1:0]   valid_reg;
    pps_entry_t         entry_mem [SLOTS];
    pps_entry_t         rd_data_reg;

    logic [SLOT_W-1:0]  idx_reg;
    logic [TIME_W-1:0]  time_reg;

    logic [ID_W-1:0]    in_id_reg;
    logic [TIME_W-1:0]  in_burst_reg;
    logic [PRIO_W-1:0]  in_prio_reg;

    logic               cmp_pend_reg;
    logic               cmp_valid_reg;
    logic [SLOT_W-1:0]  cmp_slot_reg;

    logic               best_found_reg;
    logic [SLOT_W-1:0]  best_slot_reg;
    logic [PRIO_W-1:0]  best_prio_reg;
    logic [TIME_W-1:0]  best_arr_reg;

    pps_status_t        status_reg;
    logic [ID_W-1:0]    run_id_reg;
    logic [TIME_W-1:0]  fin_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [TIME_W-1:0]  wt_reg;

    logic [SLOT_W-1:0]  rd_addr;
    logic               better;
    logic [TIME_W-1:0]  rem_next;
    pps_entry_t         wr_entry;
    logic [SLOT_W-1:0]  wr_addr;
    logic               wr_en;

    assign stat.slot_free  = !valid_reg[idx_reg];
    assign stat.idx_last   = (idx_reg == SLOT_W'(SLOTS - 1));
    assign stat.best_found = best_found_reg;

    assign rd_addr  = cmd.best_rd ? best_slot_reg : idx_reg;
    assign rem_next = rd_data_reg.remaining - 1'b1;

    // strict compares in ascending slot order leave ties with the lower slot
    assign better = !best_found_reg
                 || (rd_data_reg.priority_lvl < best_prio_reg)
                 || ((rd_data_reg.priority_lvl == best_prio_reg)
                     && (rd_data_reg.arrival < best_arr_reg));

    always_comb
    begin
        wr_entry = rd_data_reg;
        wr_addr  = best_slot_reg;
        wr_en    = 1'b0;
        if (cmd.write_job && (in_burst_reg != '0))
        begin
            wr_entry.job_id       = in_id_reg;
            wr_entry.arrival      = time_reg;
            wr_entry.burst        = in_burst_reg;
            wr_entry.remaining    = in_burst_reg;
            wr_entry.priority_lvl = in_prio_reg;
            wr_addr               = idx_reg;
            wr_en                 = 1'b1;
        end
        else if (cmd.update)
        begin
            wr_entry.remaining = rem_next;
            wr_en              = 1'b1;
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        if (cmd.scan_rd || cmd.best_rd)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            time_reg       <= '0;
            cmp_pend_reg   <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            cmp_pend_reg <= cmd.scan_rd;
            if (cmd.load)
            begin
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmp_pend_reg && cmp_valid_reg && better)
            begin
                best_found_reg <= 1'b1;
            end
            if (cmd.time_inc && (time_reg != '1))
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (cmd.write_job && (in_burst_reg != '0))
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            else if (cmd.update && (rem_next == '0))
            begin
                valid_reg[best_slot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_id_reg    <= job_id;
            in_burst_reg <= job_burst;
            in_prio_reg  <= job_priority;
            status_reg   <= ST_ACCEPTED;
            run_id_reg   <= '0;
            fin_reg      <= '0;
            tat_reg      <= '0;
            wt_reg       <= '0;
        end
        if (cmd.scan_rd)
        begin
            cmp_valid_reg <= valid_reg[idx_reg];
            cmp_slot_reg  <= idx_reg;
        end
        if (cmp_pend_reg && cmp_valid_reg && better)
        begin
            best_slot_reg <= cmp_slot_reg;
            best_prio_reg <= rd_data_reg.priority_lvl;
            best_arr_reg  <= rd_data_reg.arrival;
        end
        if (cmd.set_full)
        begin
            status_reg <= ST_FULL;
        end
        if (cmd.write_job && (in_burst_reg == '0))
        begin
            status_reg <= ST_ZERO;
        end
        if (cmd.set_idle)
        begin
            status_reg <= ST_IDLE;
        end
        if (cmd.update)
        begin
            run_id_reg <= rd_data_reg.job_id;
            if (rem_next == '0)
            begin
                status_reg <= ST_FINISHED;
                fin_reg    <= time_reg;
                tat_reg    <= time_reg - rd_data_reg.arrival;
            end
            else
            begin
                status_reg <= ST_RAN;
            end
        end
        if (cmd.finish && (status_reg == ST_FINISHED))
        begin
            wt_reg <= (tat_reg >= rd_data_reg.burst) ? tat_reg - rd_data_reg.burst : '0;
        end
    end

    assign status      = status_reg;
    assign run_id      = run_id_reg;
    assign finish_time = fin_reg;
    assign turnaround  = tat_reg;
    assign waiting     = wt_reg;
    assign time_now    = time_reg;

endmodule

// ===== dv/preemptive_priority_scheduler_top_test.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top_test
// Self-checking bench for the priority scheduler. A short directed table
// covers reset, field extremes, refusals and selection ties. Random arrivals
// and ticks follow. Each result word is checked against a behavioral
// scheduler, or against the fixed word given in a checked directed row.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int     CLK_PERIOD   = 4;
    localparam int     RESET_CYCLES = 10;
    localparam int     N_RANDOM     = 1080;
    localparam int     IDLE_PCT     = 18;
    localparam int     DRAIN_CYCLES = 4 * (SLOTS + 6);
    localparam longint CYCLE_LIMIT  = 400_000;

    localparam logic                KIND_ARRIVAL = 1'b0;
    localparam logic                KIND_TICK    = 1'b1;
    localparam logic [TIME_W-1:0]   TIME_MAX     = '1;
    localparam logic [PRIO_W-1:0]   PRIO_MAX     = '1;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] job_burst;
        logic [PRIO_W-1:0] job_priority;
    } sched_job_t;

    typedef struct packed {
        pps_status_t       status;
        logic [ID_W-1:0]   run_id;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] time_now;
    } sched_result_t;

    typedef struct {
        sched_job_t    job;
        int            rep;
        bit            chk;
        sched_result_t res;
    } job_row_t;

    localparam sched_result_t UNCHECKED = '0;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                kind;
    logic [ID_W-1:0]     job_id;
    logic [TIME_W-1:0]   job_burst;
    logic [PRIO_W-1:0]   job_priority;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     run_id;
    logic [TIME_W-1:0]   finish_time;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic [TIME_W-1:0]   time_now;

    // behavioral copy of the ready table
    bit                  tbl_valid [SLOTS];
    pps_entry_t          tbl_entry [SLOTS];
    logic [TIME_W-1:0]   sched_time;

    job_row_t            job_q [$];
    sched_result_t       result_q [$];
    int                  n_fail = 0;
    int                  n_rand = 0;
    longint              cycle_cnt = 0;

    // lowest slot tie group, earlier arrival group, table fill, full refusals
    job_row_t dir_rows [13] = '{
        '{'{KIND_TICK,    'h00, 'h0000, 'h00},  1, 1, '{ST_IDLE,     'h00, 0, 0, 0, 1}},
        '{'{KIND_ARRIVAL, 'h55, 'h0000, 'h12},  1, 1, '{ST_ZERO,     'h00, 0, 0, 0, 1}},
        '{'{KIND_ARRIVAL, 'hFF, 'hFFFF, 'hFF},  1, 1, '{ST_ACCEPTED, 'h00, 0, 0, 0, 1}},
        '{'{KIND_ARRIVAL, 'h00, 'h0001, 'h00},  1, 1, '{ST_ACCEPTED, 'h00, 0, 0, 0, 1}},
        '{'{KIND_TICK,    'hC3, 'hBEEF, 'h7E},  1, 1, '{ST_FINISHED, 'h00, 2, 1, 0, 2}},
        '{'{KIND_ARRIVAL, 'h0A, 'h0001, 'h05},  1, 0, UNCHECKED},
        '{'{KIND_ARRIVAL, 'h0B, 'h0001, 'h05},  1, 0, UNCHECKED},
        '{'{KIND_TICK,    'h00, 'h0000, 'h00},  1, 0, UNCHECKED},
        '{'{KIND_ARRIVAL, 'h0C, 'h0001, 'h05},  1, 0, UNCHECKED},
        '{'{KIND_TICK,    'h00, 'h0000, 'h00},  1, 0, UNCHECKED},
        '{'{KIND_ARRIVAL, 'hA5, 'h0003, 'h80}, 14, 0, UNCHECKED},
        '{'{KIND_ARRIVAL, 'h5A, 'h1234, 'h01},  1, 1, '{ST_FULL,     'h00, 0, 0, 0, 4}},
        '{'{KIND_ARRIVAL, 'h33, 'h0000, 'h00},  1, 1, '{ST_FULL,     'h00, 0, 0, 0, 4}}
    };

    preemptive_priority_scheduler_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .job_id       (job_id),
        .job_burst    (job_burst),
        .job_priority (job_priority),
        .done         (done),
        .status       (status),
        .run_id       (run_id),
        .finish_time  (finish_time),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .time_now     (time_now)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic sched_step(input sched_job_t job, output sched_result_t res);
        int                free_slot;
        int                best;
        logic [TIME_W-1:0] tat;
        res = '0;
        if (job.kind == KIND_ARRIVAL)
        begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!tbl_valid[i])
                    free_slot = i;
            if (free_slot < 0)
                res.status = ST_FULL;
            else if (job.job_burst == '0)
                res.status = ST_ZERO;
            else
            begin
                tbl_valid[free_slot]              = 1'b1;
                tbl_entry[free_slot].job_id       = job.job_id;
                tbl_entry[free_slot].arrival      = sched_time;
                tbl_entry[free_slot].burst        = job.job_burst;
                tbl_entry[free_slot].remaining    = job.job_burst;
                tbl_entry[free_slot].priority_lvl = job.job_priority;
                res.status = ST_ACCEPTED;
            end
        end
        else
        begin
            // strict compares keep the lowest slot among full ties
            best = -1;
            for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i] && (best < 0 ||
                    tbl_entry[i].priority_lvl < tbl_entry[best].priority_lvl ||
                    (tbl_entry[i].priority_lvl == tbl_entry[best].priority_lvl &&
                     tbl_entry[i].arrival < tbl_entry[best].arrival)))
                    best = i;
            if (sched_time != TIME_MAX)
                sched_time = sched_time + 1'b1;
            if (best < 0)
                res.status = ST_IDLE;
            else
            begin
                res.run_id = tbl_entry[best].job_id;
                tbl_entry[best].remaining = tbl_entry[best].remaining - 1'b1;
                if (tbl_entry[best].remaining == '0)
                begin
                    tat = sched_time - tbl_entry[best].arrival;
                    res.finish_time = sched_time;
                    res.turnaround  = tat;
                    // saturated time can leave turnaround below the burst
                    res.waiting = (tat >= tbl_entry[best].burst) ?
                                  tat - tbl_entry[best].burst : '0;
                    tbl_valid[best] = 1'b0;
                    res.status = ST_FINISHED;
                end
                else
                    res.status = ST_RAN;
            end
        end
        res.time_now = sched_time;
    endtask

    task automatic pick_item(output job_row_t row, output bit got);
        int n_valid;
        int n_large;
        int arr_pct;
        int r;
        n_valid = 0;
        n_large = 0;
        got = 1'b1;
        row.job.kind         = KIND_TICK;
        row.job.job_id       = ID_W'($urandom_range(0, 255));
        row.job.job_burst    = TIME_W'($urandom);
        row.job.job_priority = PRIO_W'($urandom);
        row.rep = 1;
        row.chk = 1'b0;
        row.res = UNCHECKED;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i])
            begin
                n_valid++;
                if (tbl_entry[i].burst > 255)
                    n_large++;
            end
        if (job_q.size() != 0)
            row = job_q.pop_front();
        else if (n_rand < N_RANDOM)
        begin
            unique case ((n_rand / 100) % 4)
                0:       arr_pct = 55;
                1:       arr_pct = 30;
                2:       arr_pct = 70;
                default: arr_pct = 45;
            endcase
            n_rand++;
            // on a full table any content is refused, so it stays fully random
            if ($urandom_range(0, 99) < arr_pct)
            begin
                row.job.kind = KIND_ARRIVAL;
                if (n_valid < SLOTS)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        row.job.job_burst = '0;
                    else if (r < 9 && n_large < 3)
                    begin
                        // long jobs stay at low urgency so the table keeps moving
                        row.job.job_burst    = TIME_W'($urandom_range(256, 65535));
                        row.job.job_priority = PRIO_W'($urandom_range(128, 255));
                    end
                    else
                    begin
                        row.job.job_burst = TIME_W'(($urandom_range(0, 3) != 0) ?
                                            $urandom_range(1, 6) : $urandom_range(7, 40));
                        r = $urandom_range(0, 99);
                        if (r < 60)
                            row.job.job_priority = PRIO_W'($urandom_range(0, 3));
                        else if (r < 75)
                            row.job.job_priority = ($urandom_range(0, 1) != 0) ?
                                                   PRIO_MAX : '0;
                    end
                end
            end
        end
        else
            got = 1'b0;
    endtask

    initial
    begin : drive
        job_row_t      cur;
        sched_result_t pred;
        bit            pending;
        bit            got;
        bit            stim_done;
        bit            quiet;
        int            gap;
        pending   = 1'b0;
        stim_done = 1'b0;
        gap       = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        kind         <= KIND_ARRIVAL;
        job_id       <= '0;
        job_burst    <= '0;
        job_priority <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_entry[i] = '0;
        end
        sched_time = '0;
        foreach (dir_rows[r])
            repeat (dir_rows[r].rep)
                job_q.insert(job_q.size(), dir_rows[r]);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        while (!stim_done || pending)
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                sched_step(cur.job, pred);
                result_q.insert(result_q.size(), cur.chk ? cur.res : pred);
                pending = 1'b0;
                quiet = (n_rand >= 300 && n_rand < 500);
                if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
                    gap = $urandom_range(1, 40);
            end
            if (pending)
                ;
            else if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else
            begin
                pick_item(cur, got);
                if (got)
                begin
                    kind         <= cur.job.kind;
                    job_id       <= cur.job.job_id;
                    job_burst    <= cur.job.job_burst;
                    job_priority <= cur.job.job_priority;
                    start        <= 1'b1;
                    pending = 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
        while (result_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0 && result_q.size() == 0)
            $display("** preemptive_priority_scheduler_top: PASSED **");
        else
            $display("** preemptive_priority_scheduler_top: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin : check
        sched_result_t want;
        if (rst_n && done)
        begin
            if (result_q.size() == 0)
            begin
                $error("result word with nothing outstanding: status %0d", status);
                n_fail++;
            end
            else
            begin
                want = result_q.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    n_fail++;
                end
                if (run_id !== want.run_id)
                begin
                    $error("run_id: expected %0d, got %0d", want.run_id, run_id);
                    n_fail++;
                end
                if (finish_time !== want.finish_time)
                begin
                    $error("finish_time: expected %0d, got %0d", want.finish_time, finish_time);
                    n_fail++;
                end
                if (turnaround !== want.turnaround)
                begin
                    $error("turnaround: expected %0d, got %0d", want.turnaround, turnaround);
                    n_fail++;
                end
                if (waiting !== want.waiting)
                begin
                    $error("waiting: expected %0d, got %0d", want.waiting, waiting);
                    n_fail++;
                end
                if (time_now !== want.time_now)
                begin
                    $error("time_now: expected %0d, got %0d", want.time_now, time_now);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("** preemptive_priority_scheduler_top: FAILED **");
            $finish;
        end
    end

endmodule
